>>> sv/sfla_pkg.sv
// Shared types and constants for the segregated free-list allocator.
// No dependencies; the engine and the top level import this package.
package sfla_pkg;

  // Default geometry of the heap
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_MAX_PAGES  = 4;

  // Block layout constants
  localparam int MIN_BLOCK = 32;
  localparam int NUM_LISTS = 4;

  // Field widths of the channels
  localparam int CMD_W  = 2;
  localparam int SIZE_W = 15;
  localparam int ADDR_W = 14;
  localparam int STAT_W = 3;
  localparam int CFGI_W = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESIZE  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADSIZE = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOMEM   = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREED   = 3'd4;

  // Configuration register indexes and reset values
  localparam logic [CFGI_W-1:0] CFG_CLASS_ONE   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_CLASS_TWO   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_CLASS_THREE = 2'd2;
  localparam logic [SIZE_W-1:0] RST_CLASS_ONE   = 15'd128;
  localparam logic [SIZE_W-1:0] RST_CLASS_TWO   = 15'd512;
  localparam logic [SIZE_W-1:0] RST_CLASS_THREE = 15'd2048;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] block_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_out;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] copy_len;
  } out_item_t;

  // Size-class limits
  typedef struct packed {
    logic [SIZE_W-1:0] class_one_max;
    logic [SIZE_W-1:0] class_two_max;
    logic [SIZE_W-1:0] class_three_max;
  } cls_cfg_t;

  // Engine status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

>>> sv/sfla_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module sfla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sfla_engine.sv
// Command sequencer of the allocator: walks and edits heap words in the heap RAM.
// Depends on sfla_pkg and sfla_ram.
module sfla_engine
  import sfla_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  item,
  input  cls_cfg_t  cls_cfg,
  input  logic      out_free,
  output eng_stat_t stat,
  output out_item_t result
);

  localparam int HEAP_BYTES = PAGE_BYTES * MAX_PAGES;
  localparam int HEAP_WORDS = HEAP_BYTES / 8;
  localparam int BW   = $clog2(HEAP_BYTES);
  localparam int SW   = (BW + 2 > 17) ? BW + 2 : 17;
  localparam int PGW  = $clog2(MAX_PAGES + 1);
  localparam int WALK = HEAP_BYTES / MIN_BLOCK + 1;
  localparam int SPW  = $clog2(WALK + 1);

  localparam logic [5:0] S_IDLE = 6'd0,  S_DISP = 6'd1,  S_A0   = 6'd2,  S_A0B  = 6'd3,
                         S_A0C  = 6'd4,  S_A1   = 6'd5,  S_A2   = 6'd6,  S_AP0  = 6'd7,
                         S_AP1  = 6'd8,  S_AP2  = 6'd9,  S_AP3  = 6'd10, S_A5   = 6'd11,
                         S_A6   = 6'd12, S_A7   = 6'd13, S_A7B  = 6'd14, S_A7C  = 6'd15,
                         S_A8   = 6'd16, S_ARET = 6'd17, S_C0   = 6'd18, S_C1   = 6'd19,
                         S_C2   = 6'd20, S_REL  = 6'd21, S_RELB = 6'd22, S_NX0  = 6'd23,
                         S_NX1  = 6'd24, S_NX2  = 6'd25, S_NX3  = 6'd26, S_R0   = 6'd27,
                         S_RSP  = 6'd28, S_RSPB = 6'd29, S_DONE = 6'd30, S_P0   = 6'd31,
                         S_P1   = 6'd32, S_L0   = 6'd33, S_L1   = 6'd34, S_L2   = 6'd35,
                         S_U0   = 6'd36, S_U1   = 6'd37, S_U2   = 6'd38, S_U3   = 6'd39,
                         S_U4   = 6'd40, S_U5   = 6'd41, S_F1   = 6'd42, S_F2   = 6'd43,
                         S_F3   = 6'd44;

  function automatic logic [1:0] class_of(input logic [31:0] s, input cls_cfg_t c);
    logic [1:0] k;
    priority if (s <= 32'(c.class_one_max))   k = 2'd0;
    else if     (s <= 32'(c.class_two_max))   k = 2'd1;
    else if     (s <= 32'(c.class_three_max)) k = 2'd2;
    else                                      k = 2'd3;
    return k;
  endfunction

  // Control state
  logic [5:0]     state_r, ret_r;
  logic [PGW-1:0] pages_r;
  logic [BW:0]    heads_r [NUM_LISTS];

  // Command and result
  logic [CMD_W-1:0]  cmd_r;
  logic [SIZE_W-1:0] req_r;
  logic [ADDR_W-1:0] a_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [STAT_W-1:0] res_st_r;
  logic [SIZE_W-1:0] res_copy_r;

  // Working registers
  logic [SW-1:0]     ob_r, osz_r, ab_r, af_r, nb_r, ps_r, x_r, xsz_r;
  logic [SIZE_W-1:0] oreq_r;
  logic [31:0]       hw_r;
  logic [SW-1:0]     p_b_r, p_sz_r, l_b_r, l_sz_r, u_b_r;
  logic              p_al_r, p_pad_r;
  logic [SIZE_W-1:0] p_req_r;
  logic [1:0]        u_idx_r, f_cls_r;
  logic [31:0]       u_nx_r, u_pv_r;
  logic [BW:0]       f_cur_r, hit_r;
  logic [SPW-1:0]    f_steps_r;
  logic              rd_oob_r;

  // Memory port signals
  logic [SW-1:0] rd_off, wr_off;
  logic          wr_en, ram_we;
  logic [63:0]   wr_data, ram_q, rdata;
  logic [31:0]   rd_sz32, hw_sz32, tag;
  logic [SW-1:0] end_w, diff_w;
  logic [16:0]   need_w;
  logic          pad_w;
  logic [1:0]    start_w, l_idx;
  logic [BW:0]   l_hd;

  // Heap RAM
  sfla_ram #(.WIDTH(64), .DEPTH(HEAP_WORDS)) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_off[BW-1:3]),
    .wdata (wr_data),
    .raddr (rd_off[BW-1:3]),
    .rdata (ram_q)
  );

  // Derived values
  always_comb begin
    rdata   = rd_oob_r ? 64'h0 : ram_q;
    rd_sz32 = {rdata[31:4], 4'h0};
    hw_sz32 = {hw_r[31:4], 4'h0};
    end_w   = SW'(pages_r) * SW'(PAGE_BYTES);
    if (req_r < 15'd16) begin
      need_w = 17'd32;
      pad_w  = 1'b1;
    end else begin
      need_w = ((17'(req_r) + 17'd15) & ~17'd15) + 17'd16;
      pad_w  = |req_r[3:0];
    end
    start_w = class_of(32'(need_w), cls_cfg);
    diff_w  = af_r - SW'(need_w);
    tag     = (32'(p_sz_r) & 32'hFFFF_FFF0) | {30'h0, p_pad_r, p_al_r};
    l_idx   = class_of(32'(l_sz_r), cls_cfg);
    l_hd    = heads_r[l_idx];
  end

  // Heap word address and write data for each step
  always_comb begin
    rd_off  = '0;
    wr_en   = 1'b0;
    wr_off  = '0;
    wr_data = 64'h0;
    unique case (state_r)
      S_AP0: rd_off = nb_r - SW'(8);
      S_A5:  rd_off = ab_r;
      S_C0:  rd_off = ob_r;
      S_C1:  rd_off = ob_r + SW'(rd_sz32) - SW'(8);
      S_NX0: rd_off = x_r + xsz_r;
      S_U0:  rd_off = u_b_r;
      S_U1:  rd_off = u_b_r + SW'(8);
      S_U2:  rd_off = u_b_r + SW'(16);
      S_F1:  rd_off = SW'(f_cur_r[BW-1:0]);
      S_F2:  rd_off = SW'(f_cur_r[BW-1:0]) + SW'(8);
      S_P0: begin
        wr_en   = 1'b1;
        wr_off  = p_b_r;
        wr_data = {32'h0, tag};
      end
      S_P1: begin
        wr_en   = 1'b1;
        wr_off  = p_b_r + p_sz_r - SW'(8);
        wr_data = {17'h0, p_req_r, tag};
      end
      S_L0: begin
        wr_en   = l_hd[BW];
        wr_off  = SW'(l_hd[BW-1:0]) + SW'(16);
        wr_data = {32'h0, 1'b1, 31'(l_b_r[BW-1:0])};
      end
      S_L1: begin
        wr_en   = 1'b1;
        wr_off  = l_b_r + SW'(8);
        wr_data = {32'h0, l_hd[BW], 31'(l_hd[BW-1:0])};
      end
      S_L2: begin
        wr_en   = 1'b1;
        wr_off  = l_b_r + SW'(16);
      end
      S_U4: begin
        if (!u_pv_r[31]) begin
          wr_en  = u_nx_r[31];
          wr_off = SW'(u_nx_r[30:0]) + SW'(16);
        end else if (!u_nx_r[31]) begin
          wr_en  = 1'b1;
          wr_off = SW'(u_pv_r[30:0]) + SW'(8);
        end else begin
          wr_en   = 1'b1;
          wr_off  = SW'(u_pv_r[30:0]) + SW'(8);
          wr_data = {32'h0, u_nx_r};
        end
      end
      S_U5: begin
        wr_en   = 1'b1;
        wr_off  = SW'(u_nx_r[30:0]) + SW'(16);
        wr_data = {32'h0, u_pv_r};
      end
      default: ;
    endcase
    ram_we = wr_en && (wr_off < SW'(HEAP_BYTES));
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pages_r <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      rd_oob_r <= !(rd_off < SW'(HEAP_BYTES));
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r      <= item.cmd;
            req_r      <= item.req_size;
            a_r        <= item.block_addr;
            res_addr_r <= '0;
            res_st_r   <= ST_OK;
            res_copy_r <= '0;
            state_r    <= S_DISP;
          end
        end
        S_DISP: begin
          ob_r <= SW'(a_r) - SW'(8);
          priority if (cmd_r == CMD_ALLOC) begin
            state_r <= S_A0;
          end else if (cmd_r == CMD_RELEASE || cmd_r == CMD_RESIZE) begin
            state_r <= S_C0;
          end else begin
            res_st_r <= ST_INVALID;
            state_r  <= S_DONE;
          end
        end
        // Allocate: size check, first page
        S_A0: begin
          if (req_r == '0 || 32'(req_r) > 32'(HEAP_BYTES)) begin
            res_st_r <= ST_BADSIZE;
            state_r  <= S_ARET;
          end else if (pages_r == '0) begin
            p_b_r   <= '0;
            p_sz_r  <= SW'(PAGE_BYTES);
            p_al_r  <= 1'b0;
            p_pad_r <= 1'b0;
            p_req_r <= '0;
            ret_r   <= S_A0B;
            state_r <= S_P0;
          end else begin
            state_r <= S_A1;
          end
        end
        S_A0B: begin
          l_b_r   <= '0;
          l_sz_r  <= SW'(PAGE_BYTES);
          ret_r   <= S_A0C;
          state_r <= S_L0;
        end
        S_A0C: begin
          pages_r <= PGW'(1);
          state_r <= S_A1;
        end
        // Search the lists
        S_A1: begin
          f_cls_r   <= start_w;
          f_cur_r   <= heads_r[start_w];
          f_steps_r <= SPW'(WALK);
          ret_r     <= S_A2;
          state_r   <= S_F1;
        end
        S_A2: begin
          if (hit_r[BW]) begin
            ab_r    <= SW'(hit_r[BW-1:0]);
            state_r <= S_A5;
          end else if (32'(pages_r) < 32'(MAX_PAGES)) begin
            nb_r    <= end_w;
            pages_r <= pages_r + PGW'(1);
            p_b_r   <= end_w;
            p_sz_r  <= SW'(PAGE_BYTES);
            p_al_r  <= 1'b0;
            p_pad_r <= 1'b0;
            p_req_r <= '0;
            ret_r   <= S_AP0;
            state_r <= S_P0;
          end else begin
            res_st_r <= ST_NOMEM;
            state_r  <= S_ARET;
          end
        end
        // New page: merge with a free block just before it
        S_AP0: state_r <= S_AP1;
        S_AP1: begin
          if (rdata[0] || rd_sz32 < 32'(MIN_BLOCK) || rd_sz32 > 32'(nb_r)) begin
            l_b_r   <= nb_r;
            l_sz_r  <= SW'(PAGE_BYTES);
            ret_r   <= S_A1;
            state_r <= S_L0;
          end else begin
            ps_r    <= SW'(rd_sz32);
            u_b_r   <= nb_r - SW'(rd_sz32);
            ret_r   <= S_AP2;
            state_r <= S_U0;
          end
        end
        S_AP2: begin
          p_b_r   <= nb_r - ps_r;
          p_sz_r  <= ps_r + SW'(PAGE_BYTES);
          p_al_r  <= 1'b0;
          p_pad_r <= 1'b0;
          p_req_r <= '0;
          ret_r   <= S_AP3;
          state_r <= S_P0;
        end
        S_AP3: begin
          l_b_r   <= nb_r - ps_r;
          l_sz_r  <= ps_r + SW'(PAGE_BYTES);
          ret_r   <= S_A1;
          state_r <= S_L0;
        end
        // Take the hit block off its list
        S_A5: state_r <= S_A6;
        S_A6: begin
          af_r    <= SW'(rd_sz32);
          u_b_r   <= ab_r;
          ret_r   <= S_A7;
          state_r <= S_U0;
        end
        // Split or pad
        S_A7: begin
          p_b_r   <= ab_r;
          p_al_r  <= 1'b1;
          p_req_r <= req_r;
          state_r <= S_P0;
          if (diff_w >= SW'(MIN_BLOCK)) begin
            p_sz_r  <= SW'(need_w);
            p_pad_r <= pad_w;
            ret_r   <= S_A7B;
          end else if (diff_w != '0) begin
            p_sz_r  <= af_r;
            p_pad_r <= 1'b1;
            ret_r   <= S_A8;
          end else begin
            p_sz_r  <= af_r;
            p_pad_r <= pad_w;
            ret_r   <= S_A8;
          end
        end
        S_A7B: begin
          p_b_r   <= ab_r + SW'(need_w);
          p_sz_r  <= diff_w;
          p_al_r  <= 1'b0;
          p_pad_r <= 1'b0;
          p_req_r <= '0;
          ret_r   <= S_A7C;
          state_r <= S_P0;
        end
        S_A7C: begin
          l_b_r   <= ab_r + SW'(need_w);
          l_sz_r  <= diff_w;
          ret_r   <= S_A8;
          state_r <= S_L0;
        end
        S_A8: begin
          res_addr_r <= ADDR_W'(ab_r + SW'(8));
          state_r    <= S_ARET;
        end
        // Return from allocate: finish, or release the old block of a move
        S_ARET: begin
          if (cmd_r == CMD_ALLOC || res_st_r != ST_OK) begin
            state_r <= S_DONE;
          end else begin
            res_copy_r <= oreq_r;
            state_r    <= S_REL;
          end
        end
        // Block check for release and resize
        S_C0: begin
          if (a_r[3:0] != 4'd8 || ob_r >= end_w) begin
            res_st_r <= ST_INVALID;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_C1;
          end
        end
        S_C1: begin
          if (rd_sz32 < 32'(MIN_BLOCK) || rd_sz32 > 32'(end_w - ob_r)) begin
            res_st_r <= ST_INVALID;
            state_r  <= S_DONE;
          end else begin
            hw_r    <= rdata[31:0];
            osz_r   <= SW'(rd_sz32);
            state_r <= S_C2;
          end
        end
        S_C2: begin
          if (rdata[31:0] != hw_r || !hw_r[0] || hw_r[3:2] != 2'b00 ||
              ((33'(rdata[63:32]) + 33'd16 != 33'(hw_sz32)) != hw_r[1])) begin
            res_st_r <= ST_INVALID;
            state_r  <= S_DONE;
          end else begin
            oreq_r  <= rdata[46:32];
            state_r <= (cmd_r == CMD_RELEASE) ? S_REL : S_R0;
          end
        end
        // Release the checked block
        S_REL: begin
          p_b_r   <= ob_r;
          p_sz_r  <= osz_r;
          p_al_r  <= 1'b0;
          p_pad_r <= 1'b0;
          p_req_r <= '0;
          ret_r   <= S_RELB;
          state_r <= S_P0;
        end
        S_RELB: begin
          x_r     <= ob_r;
          xsz_r   <= osz_r;
          state_r <= S_NX0;
        end
        // Merge with the next block, else file on a list
        S_NX0: begin
          nb_r <= x_r + xsz_r;
          if (x_r + xsz_r >= end_w) begin
            l_b_r   <= x_r;
            l_sz_r  <= xsz_r;
            ret_r   <= S_DONE;
            state_r <= S_L0;
          end else begin
            state_r <= S_NX1;
          end
        end
        S_NX1: begin
          if (rdata[0]) begin
            l_b_r   <= x_r;
            l_sz_r  <= xsz_r;
            ret_r   <= S_DONE;
            state_r <= S_L0;
          end else begin
            xsz_r   <= xsz_r + SW'(rd_sz32);
            u_b_r   <= nb_r;
            ret_r   <= S_NX2;
            state_r <= S_U0;
          end
        end
        S_NX2: begin
          p_b_r   <= x_r;
          p_sz_r  <= xsz_r;
          p_al_r  <= 1'b0;
          p_pad_r <= 1'b0;
          p_req_r <= '0;
          ret_r   <= S_NX3;
          state_r <= S_P0;
        end
        S_NX3: begin
          l_b_r   <= x_r;
          l_sz_r  <= xsz_r;
          ret_r   <= S_DONE;
          state_r <= S_L0;
        end
        // Resize decision
        S_R0: begin
          priority if (req_r == '0) begin
            res_st_r <= ST_FREED;
            state_r  <= S_REL;
          end else if (oreq_r == req_r) begin
            res_addr_r <= a_r;
            state_r    <= S_DONE;
          end else if (req_r > oreq_r && SW'(need_w) > osz_r) begin
            state_r <= S_A0;
          end else if (req_r > oreq_r || SW'(need_w) + SW'(MIN_BLOCK) > osz_r) begin
            res_addr_r <= a_r;
            p_b_r      <= ob_r;
            p_sz_r     <= osz_r;
            p_al_r     <= 1'b1;
            p_pad_r    <= (SW'(req_r) + SW'(16) != osz_r);
            p_req_r    <= req_r;
            ret_r      <= S_DONE;
            state_r    <= S_P0;
          end else begin
            res_addr_r <= a_r;
            p_b_r      <= ob_r;
            p_sz_r     <= SW'(need_w);
            p_al_r     <= 1'b1;
            p_pad_r    <= pad_w;
            p_req_r    <= req_r;
            ret_r      <= S_RSP;
            state_r    <= S_P0;
          end
        end
        S_RSP: begin
          p_b_r   <= ob_r + SW'(need_w);
          p_sz_r  <= osz_r - SW'(need_w);
          p_al_r  <= 1'b0;
          p_pad_r <= 1'b0;
          p_req_r <= '0;
          ret_r   <= S_RSPB;
          state_r <= S_P0;
        end
        S_RSPB: begin
          x_r     <= ob_r + SW'(need_w);
          xsz_r   <= osz_r - SW'(need_w);
          state_r <= S_NX0;
        end
        // Hold until the output register is free
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        // Write header and footer
        S_P0: state_r <= S_P1;
        S_P1: state_r <= ret_r;
        // Push onto the head of a list
        S_L0: state_r <= S_L1;
        S_L1: state_r <= S_L2;
        S_L2: begin
          heads_r[l_idx] <= {1'b1, l_b_r[BW-1:0]};
          state_r        <= ret_r;
        end
        // Unlink a free block
        S_U0: state_r <= S_U1;
        S_U1: begin
          u_idx_r <= class_of(rd_sz32, cls_cfg);
          state_r <= S_U2;
        end
        S_U2: begin
          u_nx_r  <= rdata[31:0];
          state_r <= S_U3;
        end
        S_U3: begin
          u_pv_r  <= rdata[31:0];
          state_r <= S_U4;
        end
        S_U4: begin
          if (!u_pv_r[31]) begin
            heads_r[u_idx_r] <= {u_nx_r[31], u_nx_r[BW-1:0]};
            state_r          <= ret_r;
          end else if (!u_nx_r[31]) begin
            state_r <= ret_r;
          end else begin
            state_r <= S_U5;
          end
        end
        S_U5: state_r <= ret_r;
        // First-fit walk over the lists
        S_F1: begin
          if (f_cur_r[BW] && f_steps_r != '0) begin
            state_r <= S_F2;
          end else if (f_cls_r == 2'd3) begin
            hit_r   <= '0;
            state_r <= ret_r;
          end else begin
            f_cls_r   <= f_cls_r + 2'd1;
            f_cur_r   <= heads_r[f_cls_r + 2'd1];
            f_steps_r <= SPW'(WALK);
          end
        end
        S_F2: begin
          if (rd_sz32 >= 32'(need_w)) begin
            hit_r   <= f_cur_r;
            state_r <= ret_r;
          end else begin
            state_r <= S_F3;
          end
        end
        S_F3: begin
          f_cur_r   <= {rdata[31], rdata[BW-1:0]};
          f_steps_r <= f_steps_r - SPW'(1);
          state_r   <= S_F1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.busy       = (state_r != S_IDLE);
  assign stat.done       = (state_r == S_DONE) && out_free;
  assign result.addr_out = (res_st_r == ST_OK) ? res_addr_r : '0;
  assign result.status   = res_st_r;
  assign result.copy_len = res_copy_r;

endmodule

>>> sv/segregated_free_list_allocator_unit.sv
// Top level of the segregated free-list allocator: configuration registers,
// output register and the command engine. Depends on sfla_pkg and sfla_engine.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | in_item_t  (cmd, req_size, block_addr)
//  out_    | output    | out_valid/stall  | out_item_t (addr_out, status, copy_len)
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// One transaction at a time: a command takes longer for each free-list node skipped,
// each empty class passed and each page added to the heap, which is followed by a
// fresh walk of the lists; the heap RAM moves one word per cycle.
// Synchronous active-low reset empties the lists and the heap; no clearing pass.
// A finished result waits in the output register while the next command runs.
module segregated_free_list_allocator_unit
  import sfla_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  cls_cfg_t  cfg_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  eng_stat_t stat;
  out_item_t result;
  logic      out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = stat.busy;
  assign cfg_ready = 1'b1;

  sfla_engine #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && !stat.busy),
    .item     (in_data),
    .cls_cfg  (cfg_r),
    .out_free (out_free),
    .stat     (stat),
    .result   (result)
  );

  // Latch configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.class_one_max   <= RST_CLASS_ONE;
      cfg_r.class_two_max   <= RST_CLASS_TWO;
      cfg_r.class_three_max <= RST_CLASS_THREE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLASS_ONE:   cfg_r.class_one_max   <= cfg_data;
        CFG_CLASS_TWO:   cfg_r.class_two_max   <= cfg_data;
        CFG_CLASS_THREE: cfg_r.class_three_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
      out_data_r  <= result;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
